[design/cmfc_pkg.sv]
package cmfc_pkg;

  localparam int DIR_W        = 16;
  localparam int MAG_W        = DIR_W;
  localparam int NUM_W        = DIR_W + 1;
  localparam int FACE_SIZE_W  = 13;
  localparam int PIXEL_W      = 21;
  localparam int FACE_W       = 3;

  localparam int COORD_FRAC_BITS_DEF = 8;
  localparam int MAX_FACE_SIZE_DEF   = 4096;
  localparam int FACE_SIZE_RESET     = 256;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_e;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } dir_beat_t;

  typedef struct packed {
    face_e              face;
    logic [PIXEL_W-1:0] pixel_x;
    logic [PIXEL_W-1:0] pixel_y;
    logic               zero_dir;
  } coord_beat_t;

  typedef struct packed {
    face_e face;
    logic  zero_dir;
  } side_t;

endpackage

[design/cmfc_select.sv]
module cmfc_select (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  cmfc_pkg::dir_beat_t      dir_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output cmfc_pkg::side_t          side_o,
  output logic [cmfc_pkg::MAG_W-1:0] mag_o,
  output logic [cmfc_pkg::NUM_W-1:0] num_x_o,
  output logic [cmfc_pkg::NUM_W-1:0] num_y_o
);
  import cmfc_pkg::*;

  localparam int SUM_W = DIR_W + 2;

  logic            s1_v_q;
  dir_beat_t       s1_dir_q;
  logic [MAG_W-1:0] s1_ax_q, s1_ay_q, s1_az_q;
  logic            s2_v_q;
  side_t           s2_side_q, s2_side_d;
  logic [MAG_W-1:0] s2_m_q, s2_m_d;
  logic [NUM_W-1:0] s2_nx_q, s2_nx_d, s2_ny_q, s2_ny_d;
  logic            en1, en2;

  logic [MAG_W-1:0] ax_d, ay_d, az_d;
  logic [MAG_W-1:0] m_sel;
  face_e           face_sel;
  logic signed [SUM_W-1:0] m_ext, cx, cy, cz;
  logic signed [SUM_W-1:0] plus_x, minus_x, plus_y, minus_y, plus_z, minus_z;
  logic            zero;

  assign en2     = !s2_v_q || ready_i;
  assign en1     = !s1_v_q || en2;
  assign ready_o = en1;

  // stage 1: magnitudes
  assign ax_d = dir_i.dir_x[DIR_W-1] ? (~dir_i.dir_x + 1'b1) : dir_i.dir_x;
  assign ay_d = dir_i.dir_y[DIR_W-1] ? (~dir_i.dir_y + 1'b1) : dir_i.dir_y;
  assign az_d = dir_i.dir_z[DIR_W-1] ? (~dir_i.dir_z + 1'b1) : dir_i.dir_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en1) begin
      s1_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_dir_q <= dir_i;
      s1_ax_q  <= ax_d;
      s1_ay_q  <= ay_d;
      s1_az_q  <= az_d;
    end
  end

  // stage 2: major axis, face and numerators
  always_comb begin
    zero = (s1_ax_q == '0) && (s1_ay_q == '0) && (s1_az_q == '0);
    priority if (s1_ax_q > s1_ay_q && s1_ax_q > s1_az_q) begin
      m_sel    = s1_ax_q;
      face_sel = s1_dir_q.dir_x[DIR_W-1] ? FACE_NEG_X : FACE_POS_X;
    end else if (s1_ay_q > s1_az_q) begin
      m_sel    = s1_ay_q;
      face_sel = s1_dir_q.dir_y[DIR_W-1] ? FACE_NEG_Y : FACE_POS_Y;
    end else begin
      m_sel    = s1_az_q;
      face_sel = s1_dir_q.dir_z[DIR_W-1] ? FACE_NEG_Z : FACE_POS_Z;
    end

    m_ext   = $signed({2'b00, m_sel});
    cx      = {{2{s1_dir_q.dir_x[DIR_W-1]}}, s1_dir_q.dir_x};
    cy      = {{2{s1_dir_q.dir_y[DIR_W-1]}}, s1_dir_q.dir_y};
    cz      = {{2{s1_dir_q.dir_z[DIR_W-1]}}, s1_dir_q.dir_z};
    plus_x  = m_ext + cx;
    minus_x = m_ext - cx;
    plus_y  = m_ext + cy;
    minus_y = m_ext - cy;
    plus_z  = m_ext + cz;
    minus_z = m_ext - cz;

    unique case (face_sel)
      FACE_POS_X: begin
        s2_nx_d = minus_z[NUM_W-1:0];
        s2_ny_d = minus_y[NUM_W-1:0];
      end
      FACE_NEG_X: begin
        s2_nx_d = plus_z[NUM_W-1:0];
        s2_ny_d = minus_y[NUM_W-1:0];
      end
      FACE_POS_Y: begin
        s2_nx_d = plus_x[NUM_W-1:0];
        s2_ny_d = plus_z[NUM_W-1:0];
      end
      FACE_NEG_Y: begin
        s2_nx_d = plus_x[NUM_W-1:0];
        s2_ny_d = minus_z[NUM_W-1:0];
      end
      FACE_POS_Z: begin
        s2_nx_d = plus_x[NUM_W-1:0];
        s2_ny_d = minus_y[NUM_W-1:0];
      end
      default: begin
        s2_nx_d = minus_x[NUM_W-1:0];
        s2_ny_d = minus_y[NUM_W-1:0];
      end
    endcase

    s2_m_d             = m_sel;
    s2_side_d.face     = face_sel;
    s2_side_d.zero_dir = zero;

    // zero vector: one over two lands on the face center
    if (zero) begin
      s2_m_d         = MAG_W'(1);
      s2_nx_d        = NUM_W'(1);
      s2_ny_d        = NUM_W'(1);
      s2_side_d.face = FACE_POS_X;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_side_q <= s2_side_d;
      s2_m_q    <= s2_m_d;
      s2_nx_q   <= s2_nx_d;
      s2_ny_q   <= s2_ny_d;
    end
  end

  assign valid_o = s2_v_q;
  assign side_o  = s2_side_q;
  assign mag_o   = s2_m_q;
  assign num_x_o = s2_nx_q;
  assign num_y_o = s2_ny_q;

endmodule

[design/cmfc_scale.sv]
module cmfc_scale #(
  parameter int FS_W   = 13,
  parameter int FRAC_W = 8,
  parameter int NW     = FS_W + cmfc_pkg::NUM_W + FRAC_W
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [FS_W-1:0]            size_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  cmfc_pkg::side_t            side_i,
  input  logic [cmfc_pkg::MAG_W-1:0] mag_i,
  input  logic [cmfc_pkg::NUM_W-1:0] num_x_i,
  input  logic [cmfc_pkg::NUM_W-1:0] num_y_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output cmfc_pkg::side_t            side_o,
  output logic [NW-1:0]              num_x_o,
  output logic [NW-1:0]              num_y_o,
  output logic [cmfc_pkg::NUM_W-1:0] den_o
);
  import cmfc_pkg::*;

  localparam int PROD_W = FS_W + NUM_W;

  logic              v_q;
  logic              en;
  side_t             side_q;
  logic [PROD_W-1:0] px_q, py_q, px_d, py_d;
  logic [NUM_W-1:0]  den_q;

  assign en      = !v_q || ready_i;
  assign ready_o = en;

  assign px_d = PROD_W'(size_i) * PROD_W'(num_x_i);
  assign py_d = PROD_W'(size_i) * PROD_W'(num_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q <= side_i;
      px_q   <= px_d;
      py_q   <= py_d;
      den_q  <= {mag_i, 1'b0};
    end
  end

  assign valid_o = v_q;
  assign side_o  = side_q;
  assign num_x_o = {px_q, {FRAC_W{1'b0}}};
  assign num_y_o = {py_q, {FRAC_W{1'b0}}};
  assign den_o   = den_q;

endmodule

[design/cmfc_div.sv]
module cmfc_div #(
  parameter int NW = 38,
  parameter int DW = 17,
  parameter int QB = 21
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  cmfc_pkg::side_t side_i,
  input  logic [NW-1:0]   num_x_i,
  input  logic [NW-1:0]   num_y_i,
  input  logic [DW-1:0]   den_i,
  output logic            valid_o,
  input  logic            ready_i,
  output cmfc_pkg::side_t side_o,
  output logic [QB-1:0]   quot_x_o,
  output logic [QB-1:0]   quot_y_o
);
  import cmfc_pkg::*;

  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  logic [QB-1:0] v_q;
  logic [QB:0]   en;
  side_t         side_q [QB];
  logic [NW-1:0] rx_q   [QB];
  logic [NW-1:0] ry_q   [QB];
  logic [QB-1:0] qx_q   [QB];
  logic [QB-1:0] qy_q   [QB];
  logic [DW-1:0] den_q  [QB];

  assign en[QB]  = ready_i;
  assign ready_o = en[0];

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int BIT = QB - 1 - j;

    logic          v_in;
    side_t         side_in;
    logic [NW-1:0] rx_in, ry_in;
    logic [QB-1:0] qx_in, qy_in;
    logic [DW-1:0] den_in;
    logic [CW-1:0] den_sh, rx_ext, ry_ext, rx_sub, ry_sub;
    logic          ge_x, ge_y;
    logic [NW-1:0] rx_d, ry_d;
    logic [QB-1:0] qx_d, qy_d;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign rx_in   = num_x_i;
      assign ry_in   = num_y_i;
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign den_in  = den_i;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign side_in = side_q[j-1];
      assign rx_in   = rx_q[j-1];
      assign ry_in   = ry_q[j-1];
      assign qx_in   = qx_q[j-1];
      assign qy_in   = qy_q[j-1];
      assign den_in  = den_q[j-1];
    end

    assign en[j] = !v_q[j] || en[j+1];

    always_comb begin
      den_sh = CW'(den_in) << BIT;
      rx_ext = CW'(rx_in);
      ry_ext = CW'(ry_in);
      ge_x   = rx_ext >= den_sh;
      ge_y   = ry_ext >= den_sh;
      rx_sub = rx_ext - den_sh;
      ry_sub = ry_ext - den_sh;
      rx_d   = ge_x ? rx_sub[NW-1:0] : rx_in;
      ry_d   = ge_y ? ry_sub[NW-1:0] : ry_in;
      qx_d   = qx_in;
      qy_d   = qy_in;
      qx_d[BIT] = ge_x;
      qy_d[BIT] = ge_y;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        side_q[j] <= side_in;
        rx_q[j]   <= rx_d;
        ry_q[j]   <= ry_d;
        qx_q[j]   <= qx_d;
        qy_q[j]   <= qy_d;
        den_q[j]  <= den_in;
      end
    end
  end

  assign valid_o  = v_q[QB-1];
  assign side_o   = side_q[QB-1];
  assign quot_x_o = qx_q[QB-1];
  assign quot_y_o = qy_q[QB-1];

endmodule

[design/cube_map_face_coord_top.sv]
// Cube map face selection and texel coordinate. Each beat on the input
// carries a signed direction vector; the block picks the face of the major
// axis (later axis wins on equal magnitudes) and returns the two face
// coordinates scaled by face_size, offset by one texel for the border, as
// unsigned fixed point with COORD_FRAC_BITS fractional bits, truncated.
// A zero vector gives face +X at the face center with zero_dir set.
// The block takes one beat per cycle unless back-pressure from the output
// has filled the pipeline. A beat passes the axis selection stages, the
// multiplication stage, one divider stage per quotient bit and the output
// register. Empty stages fill while the output is stalled. face_size is
// written through cfg_we_i; 0 is taken as 1 and values above MAX_FACE_SIZE
// as MAX_FACE_SIZE. Write it only while no beat is in flight.
module cube_map_face_coord_top #(
  parameter int COORD_FRAC_BITS = cmfc_pkg::COORD_FRAC_BITS_DEF,
  parameter int MAX_FACE_SIZE   = cmfc_pkg::MAX_FACE_SIZE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cmfc_pkg::FACE_SIZE_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  cmfc_pkg::dir_beat_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output cmfc_pkg::coord_beat_t            out_data_o
);
  import cmfc_pkg::*;

  localparam int FS_W   = $clog2(MAX_FACE_SIZE + 1);
  localparam int QB     = $clog2(MAX_FACE_SIZE) + COORD_FRAC_BITS + 1;
  localparam int NW     = FS_W + NUM_W + COORD_FRAC_BITS;
  localparam int CMP_W  = (FS_W > FACE_SIZE_W) ? FS_W : FACE_SIZE_W;
  localparam int SUM_W  = (QB > PIXEL_W) ? QB + 1 : PIXEL_W + 1;
  localparam int RST_SIZE = (FACE_SIZE_RESET > MAX_FACE_SIZE) ?
                            MAX_FACE_SIZE : FACE_SIZE_RESET;

  logic [FS_W-1:0] size_q, size_d;

  logic            sel_v, sel_rdy;
  side_t           sel_side;
  logic [MAG_W-1:0] sel_m;
  logic [NUM_W-1:0] sel_nx, sel_ny;

  logic            scl_v, scl_rdy;
  side_t           scl_side;
  logic [NW-1:0]   scl_nx, scl_ny;
  logic [NUM_W-1:0] scl_den;

  logic            div_v, div_rdy;
  side_t           div_side;
  logic [QB-1:0]   div_qx, div_qy;

  logic            out_v_q, out_en;
  coord_beat_t     out_q, out_d;
  logic [SUM_W-1:0] sum_x, sum_y;

  // saturate on write
  always_comb begin
    priority if (cfg_wdata_i == '0) begin
      size_d = FS_W'(1);
    end else if (CMP_W'(cfg_wdata_i) > CMP_W'(MAX_FACE_SIZE)) begin
      size_d = FS_W'(MAX_FACE_SIZE);
    end else begin
      size_d = FS_W'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= FS_W'(RST_SIZE);
    end else if (cfg_we_i) begin
      size_q <= size_d;
    end
  end

  cmfc_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .dir_i   (in_data_i),
    .valid_o (sel_v),
    .ready_i (sel_rdy),
    .side_o  (sel_side),
    .mag_o   (sel_m),
    .num_x_o (sel_nx),
    .num_y_o (sel_ny)
  );

  cmfc_scale #(
    .FS_W   (FS_W),
    .FRAC_W (COORD_FRAC_BITS),
    .NW     (NW)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .size_i  (size_q),
    .valid_i (sel_v),
    .ready_o (sel_rdy),
    .side_i  (sel_side),
    .mag_i   (sel_m),
    .num_x_i (sel_nx),
    .num_y_i (sel_ny),
    .valid_o (scl_v),
    .ready_i (scl_rdy),
    .side_o  (scl_side),
    .num_x_o (scl_nx),
    .num_y_o (scl_ny),
    .den_o   (scl_den)
  );

  cmfc_div #(
    .NW (NW),
    .DW (NUM_W),
    .QB (QB)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (scl_v),
    .ready_o  (scl_rdy),
    .side_i   (scl_side),
    .num_x_i  (scl_nx),
    .num_y_i  (scl_ny),
    .den_i    (scl_den),
    .valid_o  (div_v),
    .ready_i  (div_rdy),
    .side_o   (div_side),
    .quot_x_o (div_qx),
    .quot_y_o (div_qy)
  );

  // border offset of one texel
  assign sum_x = SUM_W'(div_qx) + (SUM_W'(1) << COORD_FRAC_BITS);
  assign sum_y = SUM_W'(div_qy) + (SUM_W'(1) << COORD_FRAC_BITS);

  always_comb begin
    out_d.face     = div_side.face;
    out_d.pixel_x  = sum_x[PIXEL_W-1:0];
    out_d.pixel_y  = sum_y[PIXEL_W-1:0];
    out_d.zero_dir = div_side.zero_dir;
  end

  assign out_en  = !out_v_q || out_ready_i;
  assign div_rdy = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import cmfc_pkg::*;

  localparam int FRAC_BITS   = COORD_FRAC_BITS_DEF;
  localparam int SIZE_MAX    = MAX_FACE_SIZE_DEF;
  localparam int DRAIN_WAIT  = 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_BEATS = 138;

  // expected coordinates of directions in flight
  class coord_board;
    coord_beat_t pending_coords[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function logic [PIXEL_W-1:0] scaled_texel(longint size, longint n, longint m);
      longint q;
      q = ((size * n) << FRAC_BITS) / (2 * m);
      return PIXEL_W'(q + (longint'(1) << FRAC_BITS));
    endfunction

    static function coord_beat_t predict_coord(dir_beat_t d, logic [FACE_SIZE_W-1:0] size_reg);
      longint      c[3];
      longint      a[3];
      longint      size;
      longint      m;
      longint      nx;
      longint      ny;
      int          axis;
      face_e       f;
      coord_beat_t r;
      c[0] = d.dir_x;
      c[1] = d.dir_y;
      c[2] = d.dir_z;
      for (int i = 0; i < 3; i++) a[i] = (c[i] < 0) ? -c[i] : c[i];
      size = size_reg;
      if (size < 1) size = 1;
      if (size > SIZE_MAX) size = SIZE_MAX;
      if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
        r.face     = FACE_POS_X;
        r.pixel_x  = scaled_texel(size, 1, 1);
        r.pixel_y  = scaled_texel(size, 1, 1);
        r.zero_dir = 1'b1;
        return r;
      end
      // later axis wins on equal magnitude
      if (a[0] > a[1] && a[0] > a[2]) axis = 0;
      else if (a[1] > a[2]) axis = 1;
      else axis = 2;
      m = a[axis];
      f = face_e'(axis * 2 + ((c[axis] < 0) ? 1 : 0));
      case (f)
        FACE_POS_X: begin nx = m - c[2]; ny = m - c[1]; end
        FACE_NEG_X: begin nx = m + c[2]; ny = m - c[1]; end
        FACE_POS_Y: begin nx = m + c[0]; ny = m + c[2]; end
        FACE_NEG_Y: begin nx = m + c[0]; ny = m - c[2]; end
        FACE_POS_Z: begin nx = m + c[0]; ny = m - c[1]; end
        default: begin nx = m - c[0]; ny = m - c[1]; end
      endcase
      r.face     = f;
      r.pixel_x  = scaled_texel(size, nx, m);
      r.pixel_y  = scaled_texel(size, ny, m);
      r.zero_dir = 1'b0;
      return r;
    endfunction

    function void note_dir(dir_beat_t d, logic [FACE_SIZE_W-1:0] size_reg);
      pending_coords.push_back(predict_coord(d, size_reg));
    endfunction

    function void check_coord(coord_beat_t got);
      coord_beat_t exp_c;
      if (pending_coords.size() == 0) begin
        $display("%0t: unexpected beat face=%0d x=%0d y=%0d zero=%0b", $time,
                 got.face, got.pixel_x, got.pixel_y, got.zero_dir);
        mismatches++;
        return;
      end
      exp_c = pending_coords.pop_front();
      if (got.face !== exp_c.face) begin
        $display("%0t: face expected %0d actual %0d", $time, exp_c.face, got.face);
        mismatches++;
      end
      if (got.pixel_x !== exp_c.pixel_x) begin
        $display("%0t: pixel_x expected %0d actual %0d", $time, exp_c.pixel_x, got.pixel_x);
        mismatches++;
      end
      if (got.pixel_y !== exp_c.pixel_y) begin
        $display("%0t: pixel_y expected %0d actual %0d", $time, exp_c.pixel_y, got.pixel_y);
        mismatches++;
      end
      if (got.zero_dir !== exp_c.zero_dir) begin
        $display("%0t: zero_dir expected %0b actual %0b", $time, exp_c.zero_dir,
                 got.zero_dir);
        mismatches++;
      end
    endfunction

    function int pending_count();
      return pending_coords.size();
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [FACE_SIZE_W-1:0] cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  dir_beat_t              in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  coord_beat_t            out_data_o;

  logic [FACE_SIZE_W-1:0] face_size_now = FACE_SIZE_W'(FACE_SIZE_RESET);
  bit                     idling        = 1'b0;
  bit                     hold_off_req  = 1'b0;
  int                     cycle_count   = 0;
  coord_board             board         = new();

  cube_map_face_coord_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_dir(in_data_i, face_size_now);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_coord(out_data_o);
  end

  function automatic int pick_gap();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    int  span;
    bit  rdy;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rdy  = 1'b0;
        span = 400;
      end else if (!idling) begin
        rdy  = 1'b1;
        span = 1;
      end else if ($urandom_range(0, 1)) begin
        rdy  = 1'b1;
        span = $urandom_range(1, 12);
      end else begin
        rdy  = 1'b0;
        span = pick_gap();
        if (span == 0) span = 1;
      end
      out_ready_i <= rdy;
      repeat (span) @(posedge clk_i);
    end
  end

  function automatic dir_beat_t mk_dir(int x, int y, int z);
    dir_beat_t d;
    d.dir_x = DIR_W'(x);
    d.dir_y = DIR_W'(y);
    d.dir_z = DIR_W'(z);
    return d;
  endfunction

  function automatic logic signed [DIR_W-1:0] rand_comp();
    int v;
    case ($urandom_range(0, 9))
      5, 6: v = $urandom_range(0, 6) - 3;
      7: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          3: v = 1;
          default: v = 0;
        endcase
      end
      8: v = $urandom_range(0, 510) - 255;
      default: v = $urandom;
    endcase
    return DIR_W'(v);
  endfunction

  function automatic dir_beat_t rand_dir();
    dir_beat_t d;
    int        r;
    d.dir_x = rand_comp();
    d.dir_y = rand_comp();
    d.dir_z = rand_comp();
    r = $urandom_range(0, 99);
    if (r < 3) begin
      d = '0;
    end else if (r < 20) begin
      // equal magnitudes on two axes
      case ($urandom_range(0, 2))
        0: d.dir_y = $urandom_range(0, 1) ? d.dir_x : -d.dir_x;
        1: d.dir_z = $urandom_range(0, 1) ? d.dir_x : -d.dir_x;
        default: d.dir_z = $urandom_range(0, 1) ? d.dir_y : -d.dir_y;
      endcase
    end
    return d;
  endfunction

  task automatic send_dir(input dir_beat_t d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_face_size(input logic [FACE_SIZE_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    face_size_now = v;
    @(posedge clk_i);
  endtask

  initial begin
    dir_beat_t              directed[$];
    logic [FACE_SIZE_W-1:0] sizes[8];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats at the reset face size
    directed = '{mk_dir(0, 0, 0), mk_dir(32767, 0, 0), mk_dir(-32768, 0, 0),
                 mk_dir(0, 32767, 0), mk_dir(0, -32768, 0), mk_dir(0, 0, 32767),
                 mk_dir(0, 0, -32768), mk_dir(5, 5, 0), mk_dir(5, 0, 5),
                 mk_dir(5, 5, 5), mk_dir(-5, 5, 0), mk_dir(-32768, -32768, -32768),
                 mk_dir(-32768, 32767, 0), mk_dir(100, -100, 0), mk_dir(7, 3, -7),
                 mk_dir(1000, 999, -999), mk_dir(-1000, -999, 999), mk_dir(1, 0, 0),
                 mk_dir(-1, 0, 0), mk_dir(0, 0, 1), mk_dir(-32768, 32767, -32767),
                 mk_dir(300, -299, 150), mk_dir(12345, -23456, 7890),
                 mk_dir(1, -1, 1)};
    foreach (directed[i]) send_dir(directed[i]);
    drain();

    sizes = '{1, 4096, 0, 8191, 4097, 256, FACE_SIZE_W'($urandom_range(1, SIZE_MAX)),
              FACE_SIZE_W'($urandom)};
    foreach (sizes[p]) begin
      write_face_size(sizes[p]);
      idling = (p != 1 && p != 3);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (p == 3 && i == 20) hold_off_req = 1'b1;
        send_dir(rand_dir());
      end
      drain();
    end

    if (board.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
design/cmfc_pkg.sv
design/cmfc_select.sv
design/cmfc_scale.sv
design/cmfc_div.sv
design/cube_map_face_coord_top.sv
sim/tb.sv
